/* design/pit_pkg.sv */
`timescale 1ns / 1ps
package pit_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int TS_W = 64;
   localparam int ID_W = 32;
   localparam int STAT_W = 2;

   localparam logic signed [TS_W-1:0] TS_MINUS_INF = {1'b1, {(TS_W-1){1'b0}}};
   localparam logic signed [TS_W-1:0] TS_PLUS_INF = {1'b0, {(TS_W-1){1'b1}}};

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   // what interval an insert writes
   typedef enum logic [1:0] {
      INS_OPEN,    // [ts, +inf)
      INS_BACK,    // (-inf, ts]
      INS_CLOSE    // [open start, ts)
   } ins_kind_type;

   typedef struct packed {
      logic                  capture;
      logic                  scan;
      logic                  rescan;
      logic                  write;
      ins_kind_type          kind;
      logic                  emit;
      logic [STAT_W-1:0]     res_status;
      logic                  res_closed;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic op_stop;
      logic present;
      logic open_found;
      logic free_found;
      logic match_open;
      logic match_back;
      logic match_close;
      logic out_free;
   } sts_type;

   typedef struct packed {
      logic signed [TS_W-1:0] start_ts;
      logic signed [TS_W-1:0] stop_ts;
      logic [ID_W-1:0]        who;
   } entry_type;

endpackage

/* design/pit_if.sv */
`timescale 1ns / 1ps
interface pit_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic signed [pit_pkg::TS_W-1:0] timestamp;
   logic [pit_pkg::ID_W-1:0]       entity_id;

   modport source (output valid, output operation, output timestamp, output entity_id,
                   input ready);
   modport sink (input valid, input operation, input timestamp, input entity_id,
                 output ready);
endinterface

interface pit_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pit_pkg::STAT_W-1:0]    status;
   logic                          interval_closed;

   modport source (output valid, output status, output interval_closed, input ready);
   modport sink (input valid, input status, input interval_closed, output ready);
endinterface

/* design/pit_datapath.sv */
`timescale 1ns / 1ps
module pit_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  pit_pkg::cmd_type                 cmd,
   output pit_pkg::sts_type                 sts,
   input  logic                             req_operation,
   input  logic signed [pit_pkg::TS_W-1:0]  req_timestamp,
   input  logic [pit_pkg::ID_W-1:0]         req_entity_id,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pit_pkg::STAT_W-1:0]       rsp_status,
   output logic                             rsp_interval_closed
);
   import pit_pkg::*;

   entry_type mem [TABLE_DEPTH];
   logic      valid_ff [TABLE_DEPTH];

   logic                   op_ff;
   logic signed [TS_W-1:0] ts_ff;
   logic [ID_W-1:0]        who_ff;
   logic                   pass_ff;

   logic [CNT_W-1:0] addr_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_bit_ff;
   entry_type        rdata_ff;

   logic                   present_ff;
   logic                   open_found_ff;
   logic [IDX_W-1:0]       open_idx_ff;
   logic signed [TS_W-1:0] open_start_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;
   logic                   match_open_ff;
   logic                   match_back_ff;
   logic                   match_close_ff;

   logic                   rsp_valid_ff;
   logic [STAT_W-1:0]      rsp_status_ff;
   logic                   rsp_closed_ff;

   logic                   issue;
   logic                   hit_who;
   logic                   hit_present;
   logic [IDX_W-1:0]       wr_idx;
   entry_type              wdata;

   assign issue = cmd.scan && (addr_ff < CNT_W'(TABLE_DEPTH));
   assign hit_who = rd_bit_ff && (rdata_ff.who == who_ff);
   assign hit_present = hit_who && !(ts_ff < rdata_ff.start_ts) && (ts_ff < rdata_ff.stop_ts);

   always_comb begin
      wr_idx = free_idx_ff;
      wdata.who = who_ff;
      wdata.start_ts = ts_ff;
      wdata.stop_ts = TS_PLUS_INF;
      case (cmd.kind)
         INS_OPEN: begin
            wdata.start_ts = ts_ff;
            wdata.stop_ts = TS_PLUS_INF;
         end
         INS_BACK: begin
            wdata.start_ts = TS_MINUS_INF;
            wdata.stop_ts = ts_ff;
         end
         INS_CLOSE: begin
            wdata.start_ts = open_start_ff;
            wdata.stop_ts = ts_ff;
            // freed open slot competes with the lowest free slot of the first pass
            if (!(free_found_ff && (free_idx_ff < open_idx_ff))) begin
               wr_idx = open_idx_ff;
            end
         end
         default: begin
            wdata.start_ts = ts_ff;
            wdata.stop_ts = TS_PLUS_INF;
         end
      endcase
   end

   // table storage, registered read
   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= mem[addr_ff[IDX_W-1:0]];
      end
      if (cmd.write) begin
         mem[wr_idx] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.rescan) begin
            valid_ff[open_idx_ff] <= 1'b0;
         end
         if (cmd.write) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_operation;
         ts_ff <= req_timestamp;
         who_ff <= req_entity_id;
      end
      if (issue) begin
         rd_idx_ff <= addr_ff[IDX_W-1:0];
         rd_bit_ff <= valid_ff[addr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         rd_vld_ff <= 1'b0;
         pass_ff <= 1'b0;
         present_ff <= 1'b0;
         open_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         match_open_ff <= 1'b0;
         match_back_ff <= 1'b0;
         match_close_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (issue) begin
            addr_ff <= addr_ff + CNT_W'(1);
         end
         if (cmd.capture) begin
            addr_ff <= '0;
            pass_ff <= 1'b0;
            present_ff <= 1'b0;
            open_found_ff <= 1'b0;
            free_found_ff <= 1'b0;
            match_open_ff <= 1'b0;
            match_back_ff <= 1'b0;
         end else if (cmd.rescan) begin
            addr_ff <= '0;
            pass_ff <= 1'b1;
            match_close_ff <= 1'b0;
         end else if (rd_vld_ff) begin
            if (!pass_ff) begin
               if (hit_present) begin
                  present_ff <= 1'b1;
               end
               if (hit_who && (rdata_ff.stop_ts == TS_PLUS_INF) && !open_found_ff) begin
                  open_found_ff <= 1'b1;
               end
               if (!rd_bit_ff && !free_found_ff) begin
                  free_found_ff <= 1'b1;
               end
               if (hit_who && (rdata_ff.start_ts == ts_ff) &&
                   (rdata_ff.stop_ts == TS_PLUS_INF)) begin
                  match_open_ff <= 1'b1;
               end
               if (hit_who && (rdata_ff.start_ts == TS_MINUS_INF) &&
                   (rdata_ff.stop_ts == ts_ff)) begin
                  match_back_ff <= 1'b1;
               end
            end else begin
               if (hit_who && (rdata_ff.start_ts == open_start_ff) &&
                   (rdata_ff.stop_ts == ts_ff)) begin
                  match_close_ff <= 1'b1;
               end
            end
         end
      end
   end

   // first-hit indexes and open start; qualified by the flags above
   always_ff @(posedge clock) begin
      if (rd_vld_ff && !pass_ff && !cmd.capture && !cmd.rescan) begin
         if (hit_who && (rdata_ff.stop_ts == TS_PLUS_INF) && !open_found_ff) begin
            open_idx_ff <= rd_idx_ff;
            open_start_ff <= rdata_ff.start_ts;
         end
         if (!rd_bit_ff && !free_found_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.res_status;
         rsp_closed_ff <= cmd.res_closed;
      end
   end

   assign sts.scan_done = (addr_ff == CNT_W'(TABLE_DEPTH)) && !rd_vld_ff;
   assign sts.op_stop = op_ff;
   assign sts.present = present_ff;
   assign sts.open_found = open_found_ff;
   assign sts.free_found = free_found_ff;
   assign sts.match_open = match_open_ff;
   assign sts.match_back = match_back_ff;
   assign sts.match_close = match_close_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_interval_closed = rsp_closed_ff;

endmodule

/* design/pit_controller.sv */
`timescale 1ns / 1ps
module pit_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pit_pkg::sts_type sts,
   output pit_pkg::cmd_type cmd
);
   import pit_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RESCAN,
      ST_CLOSE,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic              res_closed_ff, res_closed_in;

   always_comb begin
      state_in = state_ff;
      res_status_in = res_status_ff;
      res_closed_in = res_closed_ff;
      cmd = '0;
      cmd.kind = INS_OPEN;
      cmd.res_status = res_status_ff;
      cmd.res_closed = res_closed_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_closed_in = 1'b0;
            res_status_in = STAT_OK;
            state_in = ST_FINISH;
            if (!sts.op_stop) begin
               if (sts.present) begin
                  res_status_in = STAT_DUP;
               end else if (!sts.match_open) begin
                  if (sts.free_found) begin
                     cmd.write = 1'b1;
                     cmd.kind = INS_OPEN;
                  end else begin
                     res_status_in = STAT_FULL;
                  end
               end
            end else if (!sts.present) begin
               res_status_in = STAT_DUP;
               if (!sts.match_back) begin
                  if (sts.free_found) begin
                     cmd.write = 1'b1;
                     cmd.kind = INS_BACK;
                  end else begin
                     res_status_in = STAT_FULL;
                  end
               end
            end else if (sts.open_found) begin
               // free the open slot, then look for a duplicate of the closed interval
               cmd.rescan = 1'b1;
               res_closed_in = 1'b1;
               state_in = ST_RESCAN;
            end
         end
         ST_RESCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            cmd.write = !sts.match_close;
            cmd.kind = INS_CLOSE;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         res_status_ff <= STAT_OK;
         res_closed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         res_status_ff <= res_status_in;
         res_closed_ff <= res_closed_in;
      end
   end

endmodule

/* design/presence_interval_table_core.sv */
`timescale 1ns / 1ps
// Presence interval table: 256 slots of (start, end, entity). A start item opens
// [ts, +inf) unless the entity is already present; a stop item closes the entity's
// lowest open interval at ts, or records (-inf, ts] when the entity was not present.
// Every item gives exactly one result (status, interval_closed). One item is in work
// at a time. Each item scans all slots through the single read port of the slot
// memory, one slot per cycle, then drains the read pipeline and passes through a
// decide state and a finish state. A stop that closes an interval also takes a
// second scan for duplicates and a close state that writes the closed interval
// unless a duplicate is found. The result sits in an output register. An item
// whose result register still holds an unaccepted result waits in its finish state
// until that result is taken. The next item is accepted as soon as the controller
// is idle. Valid bits are flip-flops cleared by reset, so no clearing pass is
// needed after reset.
module presence_interval_table_core (
   input  logic clock,
   input  logic reset,
   pit_req_if.sink   req_chan,
   pit_rsp_if.source rsp_chan
);
   import pit_pkg::*;

   cmd_type cmd;   // controller -> datapath
   sts_type sts;   // datapath -> controller

   pit_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot memory, scan pipeline, match flags and the result register
   pit_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_operation       (req_chan.operation),
      .req_timestamp       (req_chan.timestamp),
      .req_entity_id       (req_chan.entity_id),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_status          (rsp_chan.status),
      .rsp_interval_closed (rsp_chan.interval_closed)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the presence interval table core.
// A scoreboard object keeps its own copy of the slot table and predicts the
// status / interval_closed pair for every item that the core accepts. The
// stimulus runs a directed pass first, then three random phases. The first
// random phase is mostly start/stop pairs per entity, with noise. The second
// phase fills the table, and the third runs mixed traffic against a full table.
module testbench;
   import pit_pkg::*;

   localparam bit OP_START = 1'b0;
   localparam bit OP_STOP  = 1'b1;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 6;
   // Slowest honest run: ~560 items, all closing stops, plus idling and one
   // long hold-off; the limit allows several times that.
   localparam int CYCLE_LIMIT   = 1_500_000;
   // A closing stop needs two full scans, so wait past that at the end.
   localparam int SETTLE_CYCLES = 600;
   localparam int HOLD_CYCLES   = 1500;
   localparam int HOLD_AT_ITEM  = 60;
   localparam int IDLE_PCT      = 9;
   localparam int POOL_SIZE     = 6;

   typedef struct {
      status_type status;
      bit         closed;
   } outcome_type;

   // Scoreboard: shadow slot table plus the queue of outcomes still owed.
   class presence_tracker_type;
      bit                     slot_used [TABLE_DEPTH];
      bit signed [TS_W-1:0]   slot_from [TABLE_DEPTH];
      bit signed [TS_W-1:0]   slot_to   [TABLE_DEPTH];
      bit        [ID_W-1:0]   slot_who  [TABLE_DEPTH];
      outcome_type            pending_outcomes[$];
      int                     error_count;

      // present at ts: some interval of this entity has from <= ts < to
      function bit present_at(bit signed [TS_W-1:0] ts, bit [ID_W-1:0] who);
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i] && slot_who[i] == who && ts >= slot_from[i] && ts < slot_to[i])
               return 1'b1;
         end
         return 1'b0;
      endfunction

      // merge with an identical entry, else take the lowest free slot;
      // returns 0 when the table is full
      function bit store_interval(bit signed [TS_W-1:0] from_ts,
                                  bit signed [TS_W-1:0] to_ts, bit [ID_W-1:0] who);
         int free_slot;
         free_slot = -1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i]) begin
               if (slot_from[i] == from_ts && slot_to[i] == to_ts && slot_who[i] == who)
                  return 1'b1;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (free_slot < 0)
            return 1'b0;
         slot_used[free_slot] = 1'b1;
         slot_from[free_slot] = from_ts;
         slot_to[free_slot]   = to_ts;
         slot_who[free_slot]  = who;
         return 1'b1;
      endfunction

      function void note_event(bit op, bit signed [TS_W-1:0] ts, bit [ID_W-1:0] who);
         outcome_type res;
         bit          present;
         res.status = STAT_OK;
         res.closed = 1'b0;
         present    = present_at(ts, who);
         if (op == OP_START) begin
            if (present)
               res.status = STAT_DUP;
            else if (!store_interval(ts, TS_PLUS_INF, who))
               res.status = STAT_FULL;
         end else if (!present) begin
            res.status = store_interval(TS_MINUS_INF, ts, who) ? STAT_DUP : STAT_FULL;
         end else begin
            // close the lowest open slot of this entity; the slot is freed
            // first, so the re-insert can merge or land in a lower hole
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i] && slot_who[i] == who && slot_to[i] == TS_PLUS_INF) begin
                  slot_used[i] = 1'b0;
                  void'(store_interval(slot_from[i], ts, who));
                  res.closed = 1'b1;
                  break;
               end
            end
         end
         pending_outcomes.push_back(res);
      endfunction

      function void check_outcome(logic [STAT_W-1:0] status, logic closed);
         outcome_type want;
         if (pending_outcomes.size() == 0) begin
            $display("%0t ERROR: unexpected result, expected none, got status %0d closed %0d",
                     $time, status, closed);
            error_count++;
            return;
         end
         want = pending_outcomes.pop_front();
         if (status !== want.status) begin
            $display("%0t ERROR: status expected %0d, got %0d", $time, want.status, status);
            error_count++;
         end
         if (closed !== want.closed) begin
            $display("%0t ERROR: interval_closed expected %0d, got %0d",
                     $time, want.closed, closed);
            error_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   pit_req_if req_chan ();
   pit_rsp_if rsp_chan ();

   presence_interval_table_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   presence_tracker_type tracker = new;

   int unsigned accepted_items = 0;
   int unsigned cycle_count    = 0;
   bit          calm           = 1'b0;   // no idling on either side while set
   bit          hold_done      = 1'b0;

   // entity pool and per-entity time cursors for well-formed start/stop pairs
   bit        [ID_W-1:0] id_pool     [POOL_SIZE];
   bit signed [TS_W-1:0] pool_cursor [POOL_SIZE];
   bit                   pool_open   [POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: random backpressure, plus one long hold-off once enough
   // items are in so that the core fills and stalls its input.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && !hold_done && accepted_items >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Result monitor: outputs are sampled at the edge, before NBA updates.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_outcome(rsp_chan.status, rsp_chan.interval_closed);
   end

   // Offer one item, with an occasional gap ahead of it; returns after the
   // accepting edge with valid still high.
   task automatic send_event(bit op, bit signed [TS_W-1:0] ts, bit [ID_W-1:0] who);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.timestamp <= ts;
      req_chan.entity_id <= who;
      do
         @(posedge clock);
      while (!req_chan.ready);
      tracker.note_event(op, ts, who);
      accepted_items++;
   endtask

   function automatic bit signed [TS_W-1:0] random_ts();
      return {$urandom, $urandom};
   endfunction

   function automatic bit signed [TS_W-1:0] extreme_ts();
      case ($urandom_range(0, 3))
         0: return TS_MINUS_INF;
         1: return TS_PLUS_INF;
         2: return TS_MINUS_INF + 1;
         default: return TS_PLUS_INF - 1;
      endcase
   endfunction

   // Mixed traffic: mostly start/stop pairs on pooled entities with
   // advancing times, the rest random operations, times and entities.
   task automatic mixed_event();
      int                   k;
      bit                   op;
      bit signed [TS_W-1:0] ts;
      bit        [ID_W-1:0] who;
      int                   pick;
      k = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 99) < 75) begin
         if (!pool_open[k]) begin
            send_event(OP_START, pool_cursor[k], id_pool[k]);
            pool_open[k] = 1'b1;
         end else begin
            ts = pool_cursor[k] + $urandom_range(1, 8);
            send_event(OP_STOP, ts, id_pool[k]);
            pool_cursor[k] = ts + $urandom_range(0, 5);
            pool_open[k]   = 1'b0;
         end
      end else begin
         op   = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 9);
         if (pick < 5)
            ts = pool_cursor[k] + $urandom_range(0, 20) - 10;
         else if (pick < 8)
            ts = random_ts();
         else
            ts = extreme_ts();
         who = ($urandom_range(0, 9) < 7) ? id_pool[k] : $urandom;
         send_event(op, ts, who);
      end
   endtask

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_START;
      req_chan.timestamp <= '0;
      req_chan.entity_id <= '0;
      reset              <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      // whole-line interval, then start while present
      send_event(OP_START, TS_MINUS_INF, 32'h0000_0000);
      send_event(OP_START, 64'sd0, 32'h0000_0000);
      // stop without presence at +inf writes (-inf, +inf): merges with the entry above
      send_event(OP_STOP, TS_PLUS_INF, 32'h0000_0000);
      // close the open interval
      send_event(OP_STOP, 64'sd0, 32'h0000_0000);
      // stop without presence twice: second one merges
      send_event(OP_STOP, 64'sd5, 32'hFFFF_FFFF);
      send_event(OP_STOP, 64'sd5, 32'hFFFF_FFFF);
      // open interval starting after the stop time; closing it twice merges
      send_event(OP_START, 64'sd20, 32'hFFFF_FFFF);
      send_event(OP_STOP, 64'sd3, 32'hFFFF_FFFF);
      send_event(OP_START, 64'sd20, 32'hFFFF_FFFF);
      send_event(OP_STOP, 64'sd3, 32'hFFFF_FFFF);
      // plain pair, then stop while present with nothing open
      send_event(OP_START, 64'sd100, 32'h0000_0007);
      send_event(OP_STOP, 64'sd200, 32'h0000_0007);
      send_event(OP_STOP, 64'sd150, 32'h0000_0007);
      // empty intervals at the extremes
      send_event(OP_START, TS_PLUS_INF, 32'h0000_0007);
      send_event(OP_STOP, TS_PLUS_INF, 32'h0000_0007);
      send_event(OP_STOP, 64'sd0, 32'h0000_0007);
      send_event(OP_START, -64'sd1, 32'h5A5A_5A5A);
      send_event(OP_STOP, TS_MINUS_INF, 32'h5A5A_5A5A);
      send_event(OP_STOP, TS_MINUS_INF + 1, 32'h5A5A_5A5A);
      send_event(OP_START, TS_PLUS_INF - 1, 32'hA5A5_A5A5);
      send_event(OP_STOP, -64'sd1, 32'hA5A5_A5A5);

      // ---- random ----
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      for (int k = 2; k < POOL_SIZE; k++)
         id_pool[k] = $urandom;
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_cursor[k] = $signed(64'($urandom_range(0, 400))) - 200;
         pool_open[k]   = 1'b0;
      end

      for (int n = 0; n < 300; n++) begin
         calm = (n >= 120 && n < 220);
         mixed_event();
      end
      calm = 1'b0;

      // fresh random starts: fills the table, then reports it full
      for (int n = 0; n < 150; n++)
         send_event(OP_START, random_ts(), $urandom);

      // mixed traffic on a full table: merges and closes still go through
      for (int n = 0; n < 80; n++)
         mixed_event();

      req_chan.valid <= 1'b0;

      while (tracker.pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.pending_outcomes.size() != 0)
         $display("%0t ERROR: %0d results never arrived", $time,
                  tracker.pending_outcomes.size());
      if (tracker.error_count == 0 && tracker.pending_outcomes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
